// File: rtl/positional_list_buffer_macros.svh
`ifndef POSITIONAL_LIST_BUFFER_MACROS_SVH
`define POSITIONAL_LIST_BUFFER_MACROS_SVH

// Same-cycle check: cons must hold whenever ante holds.
`define PLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define PLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/plb_pkg.sv
package plb_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 6;
  localparam int ENTRY_W  = 32;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_RETRIEVE = 3'd2,
    ACT_REPLACE  = 3'd3,
    ACT_TRAVERSE = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_GET,
    S_DEL_SHIFT,
    S_RET_GET,
    S_TRAV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
    logic               last;
  } result_t;

endpackage

// File: rtl/plb_mem.sv
module plb_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/plb_ctrl.sv
`include "positional_list_buffer_macros.svh"

module plb_ctrl import plb_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int ENTRY_BITS = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [POS_W-1:0]      in_position,
  input  logic [ENTRY_W-1:0]    in_entry_in,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [ENTRY_BITS-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [ENTRY_BITS-1:0] rd_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         lim_r, lim_nxt;
  logic [ENTRY_BITS-1:0] val_r, val_nxt;
  logic [ENTRY_BITS-1:0] got_r, got_nxt;
  result_t               res_r, res_nxt;

  logic [CMPW-1:0]       pos_ext, cnt_ext;
  logic [CW-1:0]         cnt_m1, cnt_p1;
  logic                  full, empty;
  logic [63:0]           val_wide, rd_wide, got_wide;
  logic [ENTRY_BITS-1:0] val_in;
  logic [ENTRY_W-1:0]    rd_entry, got_entry;

  function automatic result_t mk(input logic [ENTRY_W-1:0] e, input status_t s,
                                 input logic [CW-1:0] c, input logic l);
    result_t r;
    r.entry    = e;
    r.status   = s;
    r.count    = COUNT_W'(c);
    r.is_empty = (c == '0);
    r.is_full  = (c == CW'(CAPACITY));
    r.last     = l;
    return r;
  endfunction

  assign pos_ext   = CMPW'(in_position);
  assign cnt_ext   = CMPW'(cnt_r);
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_p1    = cnt_r + CW'(1);
  assign full      = (cnt_r == CW'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign val_wide  = 64'(in_entry_in);
  assign val_in    = val_wide[ENTRY_BITS-1:0];
  assign rd_wide   = 64'(rd_data);
  assign rd_entry  = rd_wide[ENTRY_W-1:0];
  assign got_wide  = 64'(got_r);
  assign got_entry = got_wide[ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    lim_r <= lim_nxt;
    val_r <= val_nxt;
    got_r <= got_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    val_nxt   = val_r;
    got_nxt   = got_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = res_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = idx_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pos_nxt   = pos_ext[AW-1:0];
          val_nxt   = val_in;
          lim_nxt   = cnt_m1[AW-1:0];
          state_nxt = S_RESULT;
          res_nxt   = mk('0, ST_OK, cnt_r, 1'b1);
          case (action_t'(in_action))
            ACT_INSERT: begin
              if (full) begin
                res_nxt = mk('0, ST_FULL, cnt_r, 1'b1);
              end else if (pos_ext > cnt_ext) begin
                res_nxt = mk('0, ST_BADPOS, cnt_r, 1'b1);
              end else if (pos_ext == cnt_ext) begin
                // append: no entries move
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = val_in;
                cnt_nxt = cnt_p1;
                res_nxt = mk('0, ST_OK, cnt_p1, 1'b1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = cnt_m1[AW-1:0];
                idx_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_INS_SHIFT;
              end
            end
            ACT_DELETE, ACT_RETRIEVE: begin
              if (empty) begin
                res_nxt = mk('0, ST_EMPTY, cnt_r, 1'b1);
              end else if (pos_ext >= cnt_ext) begin
                res_nxt = mk('0, ST_BADPOS, cnt_r, 1'b1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pos_ext[AW-1:0];
                idx_nxt   = pos_ext[AW-1:0];
                state_nxt = (action_t'(in_action) == ACT_DELETE) ? S_DEL_GET : S_RET_GET;
              end
            end
            ACT_REPLACE: begin
              if (pos_ext >= cnt_ext) begin
                res_nxt = mk('0, ST_BADPOS, cnt_r, 1'b1);
              end else begin
                wr_en   = 1'b1;
                wr_addr = pos_ext[AW-1:0];
                wr_data = val_in;
              end
            end
            ACT_TRAVERSE: begin
              if (empty) begin
                res_nxt = mk('0, ST_EMPTY, cnt_r, 1'b1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_TRAV;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
              res_nxt = mk('0, ST_OK, '0, 1'b1);
            end
            default: ;
          endcase
        end
      end

      S_INS_SHIFT: begin
        // move the entry just read up one slot, walk down toward the gap
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        wr_data = rd_data;
        if (idx_r == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end

      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = val_r;
        cnt_nxt   = cnt_p1;
        res_nxt   = mk('0, ST_OK, cnt_p1, 1'b1);
        state_nxt = S_RESULT;
      end

      S_DEL_GET: begin
        got_nxt = rd_data;
        if (idx_r == lim_r) begin
          cnt_nxt   = cnt_m1;
          res_nxt   = mk(rd_entry, ST_OK, cnt_m1, 1'b1);
          state_nxt = S_RESULT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DEL_SHIFT;
        end
      end

      S_DEL_SHIFT: begin
        // move the entry just read down one slot to close the gap
        wr_en   = 1'b1;
        wr_addr = idx_r - AW'(1);
        wr_data = rd_data;
        if (idx_r == lim_r) begin
          cnt_nxt   = cnt_m1;
          res_nxt   = mk(got_entry, ST_OK, cnt_m1, 1'b1);
          state_nxt = S_RESULT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_RET_GET: begin
        res_nxt   = mk(rd_entry, ST_OK, cnt_r, 1'b1);
        state_nxt = S_RESULT;
      end

      S_TRAV: begin
        // read data holds while the result stalls
        res_valid = 1'b1;
        res       = mk(rd_entry, ST_OK, cnt_r, idx_r == lim_r);
        if (res_ready) begin
          if (idx_r == lim_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  `PLB_ASSERT_NOW(a_no_rw_clash, (wr_en && rd_en), (wr_addr != rd_addr), "read and write hit one slot")
  `PLB_ASSERT_NOW(a_idle_no_result, in_ready, !res_valid, "result offered while taking a request")
  `PLB_ASSERT_NEXT(a_result_holds, (res_valid && !res_ready), (res_valid && $stable(res)), "stalled result changed")
  `PLB_ASSERT_NOW(a_ins_bounds, (state_r == S_INS_SHIFT), (idx_r >= pos_r && cnt_r != CW'(CAPACITY)), "insert shift out of range")

endmodule

// File: rtl/positional_list_buffer.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+---------------------------------------------
// request   | in_valid / in_ready   | in_action, in_position, in_entry_in
// result    | out_valid / out_ready | out_entry_out, out_status, out_count,
//           |                       | out_is_empty, out_is_full, out_last
//
// Insert moves each entry from the end of the list down to the position up one slot, then
// writes the new entry; an append writes at once. Delete moves each later entry down one
// slot. Retrieve reads one slot. Output stalls delay every result. Traverse delivers one
// result per cycle while out_ready stays high. The memory has one read and one write port.
// rst_n (synchronous) empties the list; slot contents are not cleared. A request enters
// only when the sequencer is idle; a finished result waits in the output register.
module positional_list_buffer import plb_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [POS_W-1:0]    in_position,
  input  logic [ENTRY_W-1:0]  in_entry_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENTRY_W-1:0]  out_entry_out,
  output logic [1:0]          out_status,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_is_empty,
  output logic                out_is_full,
  output logic                out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  res_valid, res_ready;
  result_t               res;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [ENTRY_BITS-1:0] wr_data, rd_data;

  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r, out_res_nxt;

  // List storage: slot i holds list position i.
  plb_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: decode the request, walk the shift, build results.
  plb_ctrl #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_position (in_position),
    .in_entry_in (in_entry_in),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Output register: load when empty or draining this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      // drop the result once taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_entry_out = out_res_r.entry;
  assign out_status    = out_res_r.status;
  assign out_count     = out_res_r.count;
  assign out_is_empty  = out_res_r.is_empty;
  assign out_is_full   = out_res_r.is_full;
  assign out_last      = out_res_r.last;

endmodule
